// ----- rtl/ordered_list_engine_top_assert.svh -----
// assertion macros for the ordered list engine
`ifndef ORDERED_LIST_ENGINE_TOP_ASSERT_SVH
`define ORDERED_LIST_ENGINE_TOP_ASSERT_SVH

// property a implies b on the next clock edge
`define OLE_ASSERT_NEXT(label, a, b) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (b)) \
		else $error("ole check failed");

// property a implies b on the same clock edge
`define OLE_ASSERT_SAME(label, a, b) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (b)) \
		else $error("ole check failed");

`endif

// ----- rtl/ole_pkg.sv -----
// ----------------------------------------------------------------------------
// ole_pkg
// types and codes shared by the ordered list engine modules
// ----------------------------------------------------------------------------
package ole_pkg;
	localparam logic [2:0] REQ_INS_FRONT  = 3'd0;
	localparam logic [2:0] REQ_APPEND     = 3'd1;
	localparam logic [2:0] REQ_INS_BEFORE = 3'd2;
	localparam logic [2:0] REQ_DELETE     = 3'd3;
	localparam logic [2:0] REQ_SEARCH     = 3'd4;
	localparam logic [2:0] REQ_DUMP       = 3'd5;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_EMPTY     = 2'd2;
	localparam logic [1:0] ST_FULL      = 2'd3;

	typedef struct packed {
		logic [2:0]  req;
		logic [31:0] new_value;
		logic [31:0] target_value;
	} ole_cmd_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DUMP
	} ole_bk_state_t;
endpackage

// ----- rtl/ole_front.sv -----
// ----------------------------------------------------------------------------
// ole_front
// accepts requests, drops unused codes and queues the rest for the back end
// ----------------------------------------------------------------------------
module ole_front import ole_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic [2:0]  req_type,
	input  logic [31:0] new_value,
	input  logic [31:0] target_value,
	output logic        full,
	output logic        empty,
	input  logic        pop,
	output ole_cmd_t    head
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	ole_cmd_t       mem_q [DEPTH];
	logic [AW-1:0]  wr_q, rd_q;
	logic [AW:0]    cnt_q;
	logic           keep;

	// unused codes never enter the queue
	assign keep  = push && (req_type <= REQ_DUMP);
	assign full  = (cnt_q == (AW+1)'(DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (keep) begin
			mem_q[wr_q] <= '{req: req_type, new_value: new_value, target_value: target_value};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (keep) begin
				wr_q <= (wr_q == AW'(DEPTH-1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == AW'(DEPTH-1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (AW+1)'(keep) - (AW+1)'(pop);
		end
	end
endmodule

// ----- rtl/ole_back.sv -----
// ----------------------------------------------------------------------------
// ole_back
// row of list cells: parallel compare, shift insert and delete, dump walk
// ----------------------------------------------------------------------------
module ole_back import ole_pkg::*; #(
	parameter int CAPACITY = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	input  ole_cmd_t    cmd,
	output logic        cmd_pop,
	output logic        busy,
	output logic        done,
	output logic [1:0]  status,
	output logic [4:0]  position,
	output logic [31:0] entry_value,
	output logic [4:0]  entry_count,
	output logic        last
);
	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	logic [31:0]   cell_q [CAPACITY];
	logic [CW-1:0] used_q;
	logic [IW-1:0] ptr_q;
	ole_bk_state_t state_q, state_d;

	logic [CAPACITY-1:0] hit;
	logic                found;
	logic [IW-1:0]       hit_idx;
	logic                is_full, is_empty, go;
	logic                do_ins, do_del;
	logic [IW-1:0]       ins_pos;
	logic [CW-1:0]       used_d;

	logic          done_d, last_d;
	logic [1:0]    status_d;
	logic [4:0]    pos_d;
	logic [31:0]   val_d;

	// match vector and first hit
	always_comb begin
		found   = 1'b0;
		hit_idx = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			hit[i] = (CW'(i) < used_q) && (cell_q[i] == cmd.target_value);
			if (hit[i] && !found) begin
				hit_idx = IW'(i);
			end
			found = found | hit[i];
		end
	end

	assign is_full  = (used_q == CW'(CAPACITY));
	assign is_empty = (used_q == '0);
	assign go       = cmd_valid && (state_q == BK_IDLE);

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (go && cmd.req == REQ_DUMP && used_q > CW'(1)) begin
					state_d = BK_DUMP;
				end
			end
			BK_DUMP: begin
				if (CW'(ptr_q) == used_q - CW'(1)) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		do_ins   = 1'b0;
		do_del   = 1'b0;
		ins_pos  = '0;
		done_d   = 1'b0;
		last_d   = 1'b1;
		status_d = ST_OK;
		pos_d    = '0;
		val_d    = '0;
		cmd_pop  = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (go) begin
					done_d  = 1'b1;
					cmd_pop = 1'b1;
					case (cmd.req)
						REQ_INS_FRONT, REQ_APPEND, REQ_INS_BEFORE: begin
							if (is_full) begin
								status_d = ST_FULL;
							end else if (cmd.req == REQ_INS_FRONT) begin
								do_ins = 1'b1;
							end else if (cmd.req == REQ_APPEND) begin
								do_ins  = 1'b1;
								ins_pos = IW'(used_q);
							end else if (is_empty) begin
								do_ins = 1'b1;
							end else if (!found) begin
								status_d = ST_NOT_FOUND;
							end else begin
								do_ins  = 1'b1;
								ins_pos = hit_idx;
							end
						end
						REQ_DELETE, REQ_SEARCH: begin
							if (is_empty) begin
								status_d = ST_EMPTY;
							end else if (!found) begin
								status_d = ST_NOT_FOUND;
							end else if (cmd.req == REQ_DELETE) begin
								do_del = 1'b1;
							end else begin
								pos_d = 5'(hit_idx) + 5'd1;
							end
						end
						REQ_DUMP: begin
							if (is_empty) begin
								status_d = ST_EMPTY;
							end else begin
								val_d  = cell_q[0];
								last_d = (used_q == CW'(1));
							end
						end
						default: done_d = 1'b0;
					endcase
				end
			end
			BK_DUMP: begin
				done_d = 1'b1;
				val_d  = cell_q[ptr_q];
				last_d = (CW'(ptr_q) == used_q - CW'(1));
			end
			default: ;
		endcase
	end

	always_comb begin
		used_d = used_q;
		if (do_ins) used_d = used_q + CW'(1);
		if (do_del) used_d = used_q - CW'(1);
	end

	// each cell takes its neighbor's value, the new value, or holds
	always_ff @(posedge clk) begin
		for (int i = 0; i < CAPACITY; i++) begin
			if (do_ins) begin
				if (IW'(i) == ins_pos) begin
					cell_q[i] <= cmd.new_value;
				end else if (IW'(i) > ins_pos && i > 0) begin
					cell_q[i] <= cell_q[(i > 0) ? i - 1 : 0];
				end
			end else if (do_del) begin
				if (IW'(i) >= hit_idx && i < CAPACITY - 1) begin
					cell_q[i] <= cell_q[(i < CAPACITY - 1) ? i + 1 : i];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			used_q  <= '0;
			ptr_q   <= '0;
			done    <= 1'b0;
		end else begin
			state_q <= state_d;
			used_q  <= used_d;
			done    <= done_d;
			if (state_q == BK_IDLE) begin
				ptr_q <= IW'(1);
			end else begin
				ptr_q <= ptr_q + IW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		status      <= status_d;
		position    <= pos_d;
		entry_value <= val_d;
		entry_count <= 5'(used_d);
		last        <= last_d;
	end

	assign busy = (state_q != BK_IDLE);
endmodule

// ----- rtl/ordered_list_engine_top.sv -----
// ----------------------------------------------------------------------------
// ordered_list_engine_top
// bounded ordered list of signed values with insert, delete, search and dump
// ----------------------------------------------------------------------------
// done is registered once the queue hands a request to an idle back end
// throughput: one transaction per cycle outside dumps; a dump holds the back
// end for each stored entry, and busy rises once the two-entry queue behind it
// fills; reset: list empty, queue empty, no strobe; results cannot be stalled
module ordered_list_engine_top import ole_pkg::*; #(
	parameter int CAPACITY = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         req_type,
	input  logic signed [31:0] new_value,
	input  logic signed [31:0] target_value,
	output logic               done,
	output logic [1:0]         status,
	output logic [4:0]         position,
	output logic signed [31:0] entry_value,
	output logic [4:0]         entry_count,
	output logic               last
);
	logic     q_full, q_empty, q_pop, bk_busy;
	ole_cmd_t q_head;

	assign busy = q_full;

	ole_front #(.DEPTH(2)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (start && !q_full),
		.req_type     (req_type),
		.new_value    (new_value),
		.target_value (target_value),
		.full         (q_full),
		.empty        (q_empty),
		.pop          (q_pop),
		.head         (q_head)
	);

	ole_back #(.CAPACITY(CAPACITY)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (!q_empty),
		.cmd         (q_head),
		.cmd_pop     (q_pop),
		.busy        (bk_busy),
		.done        (done),
		.status      (status),
		.position    (position),
		.entry_value (entry_value),
		.entry_count (entry_count),
		.last        (last)
	);

`include "ordered_list_engine_top_assert.svh"

	`OLE_ASSERT_SAME(a_pop_needs_entry, q_pop, !q_empty)
	`OLE_ASSERT_NEXT(a_pop_gives_result, q_pop, done)
	`OLE_ASSERT_SAME(a_dump_no_pop, bk_busy, !q_pop)
	`OLE_ASSERT_SAME(a_pos_only_ok, done && position != 5'd0, status == ST_OK)
endmodule

// ----- test/tb_ordered_list_engine_top.sv -----
// ----------------------------------------------------------------------------
// tb_ordered_list_engine_top
// drives list requests through the start/busy handshake and checks every
// done-strobed result against an internal list predictor, field by field
// ----------------------------------------------------------------------------
module tb_ordered_list_engine_top;
	import ole_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAP = 16;
	localparam int WATCHDOG = 20000;

	typedef struct {
		logic [1:0]  status;
		logic [4:0]  position;
		logic [31:0] entry_value;
		logic [4:0]  entry_count;
		logic        last;
	} list_result_t;

	typedef struct {
		logic [2:0]  req;
		logic [31:0] nv;
		logic [31:0] tv;
		bit          typed;
		logic [1:0]  st;
	} cmd_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [2:0] req_type = REQ_DUMP;
	logic signed [31:0] new_value = '0;
	logic signed [31:0] target_value = '0;
	logic busy, done, last;
	logic [1:0] status;
	logic [4:0] position, entry_count;
	logic signed [31:0] entry_value;

	logic [31:0] list_vals[CAP];
	int list_len = 0;
	list_result_t pending_results[$];
	int mismatches = 0;
	int results_seen = 0;
	int idle_cycles = 0;
	int sent = 0;

	ordered_list_engine_top #(.CAPACITY(CAP)) dut (.*);

	always #10 clk = ~clk;

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
		$display("mismatch %0s: got %0h expected %0h at %0t", what, got, exp, $realtime);
		mismatches++;
	endtask

	function automatic int find_value(input logic [31:0] v);
		for (int i = 0; i < list_len; i++)
			if (list_vals[i] == v)
				return i;
		return -1;
	endfunction

	function automatic list_result_t mk(input logic [1:0] st, input logic [4:0] pos,
			input logic [31:0] val, input logic lst);
		list_result_t r;
		r.status = st;
		r.position = pos;
		r.entry_value = val;
		r.entry_count = list_len[4:0];
		r.last = lst;
		return r;
	endfunction

	// updates the list copy and queues the results of one request
	task automatic predict_list(input logic [2:0] req, input logic [31:0] nv,
			input logic [31:0] tv);
		int idx;
		idx = 0;
		case (req)
			REQ_INS_FRONT, REQ_APPEND, REQ_INS_BEFORE: begin
				if (list_len >= CAP) begin
					pending_results.push_back(mk(ST_FULL, 0, 0, 1));
					return;
				end
				if (req == REQ_APPEND)
					idx = list_len;
				else if (req == REQ_INS_BEFORE && list_len != 0)
					idx = find_value(tv);
				if (idx < 0) begin
					pending_results.push_back(mk(ST_NOT_FOUND, 0, 0, 1));
					return;
				end
				for (int i = list_len; i > idx; i--)
					list_vals[i] = list_vals[i-1];
				list_vals[idx] = nv;
				list_len++;
				pending_results.push_back(mk(ST_OK, 0, 0, 1));
			end
			REQ_DELETE, REQ_SEARCH: begin
				if (list_len == 0) begin
					pending_results.push_back(mk(ST_EMPTY, 0, 0, 1));
					return;
				end
				idx = find_value(tv);
				if (idx < 0) begin
					pending_results.push_back(mk(ST_NOT_FOUND, 0, 0, 1));
					return;
				end
				if (req == REQ_DELETE) begin
					for (int i = idx; i + 1 < list_len; i++)
						list_vals[i] = list_vals[i+1];
					list_len--;
					pending_results.push_back(mk(ST_OK, 0, 0, 1));
				end else begin
					pending_results.push_back(mk(ST_OK, 5'(idx + 1), 0, 1));
				end
			end
			REQ_DUMP: begin
				if (list_len == 0)
					pending_results.push_back(mk(ST_EMPTY, 0, 0, 1));
				for (int i = 0; i < list_len; i++)
					pending_results.push_back(mk(ST_OK, 0, list_vals[i], i + 1 == list_len));
			end
			default: ;
		endcase
	endtask

	// result checker
	always @(posedge clk) begin
		list_result_t e;
		if (arst_n && done) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				report("unexpected result", status, 0);
			end else begin
				e = pending_results.pop_front();
				if (status !== e.status) report("status", status, e.status);
				if (position !== e.position) report("position", position, e.position);
				if (entry_value !== e.entry_value)
					report("entry_value", entry_value, e.entry_value);
				if (entry_count !== e.entry_count)
					report("entry_count", entry_count, e.entry_count);
				if (last !== e.last) report("last", last, e.last);
			end
		end
	end

	// watchdog on cycles with no transaction either way
	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("watchdog expired");
			$display("== FAIL ==");
			$finish;
		end
	end

	// one transaction; the caller checks a typed row's status against the predictor's
	task automatic send_cmd(input logic [2:0] req, input logic [31:0] nv,
			input logic [31:0] tv, input bit gaps);
		int gap;
		if (gaps && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 13);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req_type <= req;
		new_value <= nv;
		target_value <= tv;
		do @(posedge clk); while (busy);
		predict_list(req, nv, tv);
		sent++;
	endtask

	// random value, biased toward a value already in the list
	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 5))
			0, 1, 2: return (list_len > 0) ? list_vals[$urandom_range(0, list_len - 1)]
				: $urandom();
			3: return $urandom_range(0, 7);
			default: return $urandom();
		endcase
	endfunction

	cmd_row_t directed[] = '{
		'{REQ_DUMP,       32'h0,        32'h0,        1, ST_EMPTY},
		'{REQ_DELETE,     32'h0,        32'h5,        1, ST_EMPTY},
		'{REQ_SEARCH,     32'h0,        32'h5,        1, ST_EMPTY},
		'{REQ_INS_BEFORE, 32'h7FFFFFFF, 32'h1234,     1, ST_OK},
		'{REQ_INS_FRONT,  32'h80000000, 32'h0,        1, ST_OK},
		'{REQ_APPEND,     32'hFFFFFFFF, 32'h0,        1, ST_OK},
		'{REQ_INS_BEFORE, 32'h0,        32'h7FFFFFFF, 0, ST_OK},
		'{REQ_INS_BEFORE, 32'h1,        32'h55555555, 1, ST_NOT_FOUND},
		'{REQ_SEARCH,     32'h0,        32'hFFFFFFFF, 0, ST_OK},
		'{REQ_SEARCH,     32'h0,        32'hAAAAAAAA, 1, ST_NOT_FOUND},
		'{3'd6,           32'h1,        32'h1,        0, ST_OK},
		'{3'd7,           32'h2,        32'h2,        0, ST_OK},
		'{REQ_DUMP,       32'h0,        32'h0,        0, ST_OK},
		'{REQ_DELETE,     32'h0,        32'h80000000, 0, ST_OK},
		'{REQ_DELETE,     32'h0,        32'h12345678, 1, ST_NOT_FOUND},
		'{REQ_DUMP,       32'h0,        32'h0,        0, ST_OK}
	};

	initial begin
		int n_rand;
		logic [2:0] r;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			send_cmd(directed[i].req, directed[i].nv, directed[i].tv, 0);
			if (directed[i].typed && pending_results[$].status !== directed[i].st)
				report("table status", pending_results[$].status, directed[i].st);
		end

		// fill to capacity, then refusals when full, a search, then a full dump
		while (list_len < CAP) begin
			send_cmd(REQ_APPEND, $urandom(), 0, 1);
		end
		send_cmd(REQ_INS_FRONT, 32'h1, 0, 0);
		if (pending_results[$].status !== ST_FULL) report("full", pending_results[$].status, ST_FULL);
		send_cmd(REQ_APPEND, 32'h2, 0, 0);
		send_cmd(REQ_INS_BEFORE, 32'h3, list_vals[0], 0);
		send_cmd(REQ_SEARCH, 0, list_vals[CAP-1], 1);
		send_cmd(REQ_DUMP, 0, 0, 1);

		// sender holds off until everything has drained
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);

		n_rand = 0;
		while (n_rand < 125) begin
			case ($urandom_range(0, 19))
				0, 1, 2, 3: r = REQ_INS_FRONT;
				4, 5, 6, 7: r = REQ_APPEND;
				8, 9, 10: r = REQ_INS_BEFORE;
				11, 12, 13, 14: r = REQ_DELETE;
				15, 16: r = REQ_SEARCH;
				17, 18: r = REQ_DUMP;
				default: r = 3'($urandom_range(6, 7));
			endcase
			send_cmd(r, pick_value(), pick_value(), n_rand < 100);
			if (r <= REQ_DUMP) n_rand++;
		end
		start <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		$display("covered %0d requests, %0d results, empty, full and missing-target cases",
			sent, results_seen);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule
